// ----- rtl/core/sgm_pkg.sv -----
`default_nettype none

package sgm_pkg;

  // frame limits and field widths
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int CFG_W      = 12;
  localparam int CH_W       = 8;
  localparam int LUMA_W     = 16;
  localparam int PIX_W      = 11;
  localparam int OUT_W      = 22;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);

  // register reset values
  localparam int WIDTH_RST  = 2048;
  localparam int HEIGHT_RST = 2048;
  localparam int GAIN_RST   = 256;

  // luma weights, 8-bit rounded
  localparam int W_RED   = 77;
  localparam int W_GREEN = 150;
  localparam int W_BLUE  = 29;

  // gradient datapath widths
  localparam int GAIN_W   = 12;
  localparam int GAIN_MAX = 2048;
  localparam int FRAC_W   = 8;
  localparam int SUM3_W   = LUMA_W + 2;
  localparam int DIFF_W   = SUM3_W + 1;
  localparam int SQ_W     = 2 * (DIFF_W - 1);
  localparam int RAD_W    = 2 * DIFF_W;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 1;
  localparam int PROD_W   = DIFF_W + GAIN_W;
  localparam int CNT_W    = $clog2(ROOT_W + 1);

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_GAIN,
    REG_SINGLE_CHANNEL
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL,
    CMD_FLUSH
  } cmd_e;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic [CFG_W-1:0] gain;
    logic             single_channel;
  } cfg_t;

  // window indexed [column][row], column 0 left, row 0 top
  typedef logic [2:0][2:0][LUMA_W-1:0] win_t;

  typedef struct packed {
    win_t             win;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             last;
  } job_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_PIX,
    FS_EMIT1,
    FS_EMIT2,
    FS_FADDR,
    FS_FDATA,
    FS_FEMIT
  } front_state_e;

  typedef enum logic [2:0] {
    GS_IDLE,
    GS_SQ,
    GS_LOAD,
    GS_ROOT,
    GS_DONE
  } grad_state_e;

endpackage

`default_nettype wire

// ----- rtl/core/sgm_isqrt.sv -----
`default_nettype none

module sgm_isqrt (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     load_i,
  input  wire logic [sgm_pkg::RAD_W-1:0] radicand_i,
  input  wire logic                     step_i,
  output logic                          bit_o
);

  logic [sgm_pkg::RAD_W-1:0]  rad_q;
  logic [sgm_pkg::REM_W-1:0]  rem_q;
  logic [sgm_pkg::ROOT_W-1:0] root_q;
  logic [sgm_pkg::REM_W+1:0]  rem_sh;
  logic [sgm_pkg::REM_W+1:0]  trial;
  logic [sgm_pkg::REM_W+1:0]  rem_sub;

  // bring down the next two radicand bits and try the next root bit
  always_comb begin
    rem_sh  = {rem_q, rad_q[sgm_pkg::RAD_W-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    bit_o   = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  // one root bit per cycle while step_i is high, msb first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (load_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (step_i) begin
      rad_q  <= {rad_q[sgm_pkg::RAD_W-3:0], 2'b00};
      rem_q  <= bit_o ? rem_sub[sgm_pkg::REM_W-1:0] : rem_sh[sgm_pkg::REM_W-1:0];
      root_q <= {root_q[sgm_pkg::ROOT_W-2:0], bit_o};
    end
  end

  // partial remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= {root_q, 1'b0})
    else $error("square root remainder out of bound");

endmodule

`default_nettype wire

// ----- rtl/core/sgm_grad.sv -----
`default_nettype none

module sgm_grad (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [sgm_pkg::CFG_W-1:0]      gain_i,
  input  wire logic                           req_valid_i,
  output logic                                req_ready_o,
  input  wire sgm_pkg::job_t                  job_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [sgm_pkg::PIX_W-1:0]           pixel_x_o,
  output logic [sgm_pkg::PIX_W-1:0]           pixel_y_o,
  output logic signed [sgm_pkg::OUT_W-1:0]    grad_x_o,
  output logic signed [sgm_pkg::OUT_W-1:0]    grad_y_o,
  output logic [sgm_pkg::OUT_W-1:0]           magnitude_o,
  output logic                                last_of_frame_o
);

  sgm_pkg::grad_state_e state_q, state_d;

  logic [sgm_pkg::SUM3_W-1:0]        s_right, s_left, s_bottom, s_top;
  logic signed [sgm_pkg::DIFF_W-1:0] dx_w, dy_w;
  logic signed [sgm_pkg::DIFF_W-1:0] dx_q, dy_q;
  logic [sgm_pkg::PIX_W-1:0]         x_q, y_q;
  logic                              last_q;
  logic signed [2*sgm_pkg::DIFF_W-1:0] sqx_full, sqy_full;
  logic [sgm_pkg::SQ_W-1:0]          sqx_q, sqy_q;
  logic [sgm_pkg::RAD_W-1:0]         radicand;
  logic [sgm_pkg::GAIN_W-1:0]        g_clamp, g_q, gsh_q;
  logic signed [sgm_pkg::PROD_W-1:0] gx_q, gy_q, gx_sh, gy_sh;
  logic [sgm_pkg::PROD_W-1:0]        gx_add, gy_add, mag_add;
  logic [sgm_pkg::PROD_W-1:0]        mag_q;
  logic [sgm_pkg::CNT_W-1:0]         cnt_q;
  logic                              root_bit;
  logic                              sq_load, sq_step, out_free, out_load, start;

  logic                              ov_q;
  logic [sgm_pkg::PIX_W-1:0]         ox_q, oy_q;
  logic signed [sgm_pkg::OUT_W-1:0]  ogx_q, ogy_q;
  logic [sgm_pkg::OUT_W-1:0]         omag_q;
  logic                              olast_q;

  // sobel sums over the window columns and rows
  always_comb begin
    s_right  = sgm_pkg::SUM3_W'(job_i.win[2][0]) + {1'b0, job_i.win[2][1], 1'b0}
             + sgm_pkg::SUM3_W'(job_i.win[2][2]);
    s_left   = sgm_pkg::SUM3_W'(job_i.win[0][0]) + {1'b0, job_i.win[0][1], 1'b0}
             + sgm_pkg::SUM3_W'(job_i.win[0][2]);
    s_bottom = sgm_pkg::SUM3_W'(job_i.win[0][2]) + {1'b0, job_i.win[1][2], 1'b0}
             + sgm_pkg::SUM3_W'(job_i.win[2][2]);
    s_top    = sgm_pkg::SUM3_W'(job_i.win[0][0]) + {1'b0, job_i.win[1][0], 1'b0}
             + sgm_pkg::SUM3_W'(job_i.win[2][0]);
    dx_w     = $signed({1'b0, s_right}) - $signed({1'b0, s_left});
    dy_w     = $signed({1'b0, s_bottom}) - $signed({1'b0, s_top});
  end

  // squares, radicand and serial gain terms
  always_comb begin
    sqx_full = dx_q * dx_q;
    sqy_full = dy_q * dy_q;
    radicand = sgm_pkg::RAD_W'(sqx_q) + sgm_pkg::RAD_W'(sqy_q);
    g_clamp  = (gain_i > sgm_pkg::GAIN_W'(sgm_pkg::GAIN_MAX)) ?
               sgm_pkg::GAIN_W'(sgm_pkg::GAIN_MAX) : gain_i;
    gx_add   = gsh_q[sgm_pkg::GAIN_W-1] ?
               {{(sgm_pkg::PROD_W-sgm_pkg::DIFF_W){dx_q[sgm_pkg::DIFF_W-1]}}, dx_q} : '0;
    gy_add   = gsh_q[sgm_pkg::GAIN_W-1] ?
               {{(sgm_pkg::PROD_W-sgm_pkg::DIFF_W){dy_q[sgm_pkg::DIFF_W-1]}}, dy_q} : '0;
    mag_add  = root_bit ? sgm_pkg::PROD_W'(g_q) : '0;
    gx_sh    = gx_q >>> sgm_pkg::FRAC_W;
    gy_sh    = gy_q >>> sgm_pkg::FRAC_W;
  end

  sgm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (sq_load),
    .radicand_i (radicand),
    .step_i     (sq_step),
    .bit_o      (root_bit)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sgm_pkg::GS_IDLE: if (req_valid_i) state_d = sgm_pkg::GS_SQ;
      sgm_pkg::GS_SQ:   state_d = sgm_pkg::GS_LOAD;
      sgm_pkg::GS_LOAD: state_d = sgm_pkg::GS_ROOT;
      sgm_pkg::GS_ROOT: begin
        if (cnt_q == sgm_pkg::CNT_W'(sgm_pkg::ROOT_W - 1)) state_d = sgm_pkg::GS_DONE;
      end
      sgm_pkg::GS_DONE: if (out_free) state_d = sgm_pkg::GS_IDLE;
      default:          state_d = sgm_pkg::GS_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    out_free    = !ov_q || out_ready_i;
    req_ready_o = (state_q == sgm_pkg::GS_IDLE);
    start       = req_valid_i && req_ready_o;
    sq_load     = (state_q == sgm_pkg::GS_LOAD);
    sq_step     = (state_q == sgm_pkg::GS_ROOT);
    out_load    = (state_q == sgm_pkg::GS_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgm_pkg::GS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      dx_q   <= dx_w;
      dy_q   <= dy_w;
      x_q    <= job_i.x;
      y_q    <= job_i.y;
      last_q <= job_i.last;
    end
    if (state_q == sgm_pkg::GS_SQ) begin
      sqx_q <= sqx_full[sgm_pkg::SQ_W-1:0];
      sqy_q <= sqy_full[sgm_pkg::SQ_W-1:0];
    end
    if (sq_load) begin
      g_q   <= g_clamp;
      gsh_q <= g_clamp;
      gx_q  <= '0;
      gy_q  <= '0;
      mag_q <= '0;
      cnt_q <= '0;
    end else if (sq_step) begin
      cnt_q <= cnt_q + 1'b1;
      // root bits arrive msb first: accumulate root * gain
      mag_q <= {mag_q[sgm_pkg::PROD_W-2:0], 1'b0} + mag_add;
      // gain bits msb first: accumulate d * gain
      if (cnt_q < sgm_pkg::CNT_W'(sgm_pkg::GAIN_W)) begin
        gx_q  <= (gx_q <<< 1) + $signed(gx_add);
        gy_q  <= (gy_q <<< 1) + $signed(gy_add);
        gsh_q <= {gsh_q[sgm_pkg::GAIN_W-2:0], 1'b0};
      end
    end
  end

  // result register, frees the core while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ox_q    <= x_q;
      oy_q    <= y_q;
      ogx_q   <= gx_sh[sgm_pkg::OUT_W-1:0];
      ogy_q   <= gy_sh[sgm_pkg::OUT_W-1:0];
      omag_q  <= mag_q[sgm_pkg::FRAC_W +: sgm_pkg::OUT_W];
      olast_q <= last_q;
    end
  end

  assign out_valid_o     = ov_q;
  assign pixel_x_o       = ox_q;
  assign pixel_y_o       = oy_q;
  assign grad_x_o        = ogx_q;
  assign grad_y_o        = ogy_q;
  assign magnitude_o     = omag_q;
  assign last_of_frame_o = olast_q;

  // root iteration count stays within the root width
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sgm_pkg::GS_ROOT) |-> (cnt_q < sgm_pkg::CNT_W'(sgm_pkg::ROOT_W)))
    else $error("root iteration count overran");

  // a finished result always lands in the result register
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (ov_q && state_q == sgm_pkg::GS_IDLE))
    else $error("result not registered");

endmodule

`default_nettype wire

// ----- rtl/core/sgm_front.sv -----
`default_nettype none

module sgm_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sgm_pkg::cfg_t             cfg_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      command_i,
  input  wire logic [sgm_pkg::CH_W-1:0]  red_i,
  input  wire logic [sgm_pkg::CH_W-1:0]  green_i,
  input  wire logic [sgm_pkg::CH_W-1:0]  blue_i,
  output logic                           req_valid_o,
  input  wire logic                      req_ready_i,
  output sgm_pkg::job_t                  job_o
);

  sgm_pkg::front_state_e state_q, state_d;

  logic [sgm_pkg::LUMA_W-1:0] mid_mem [sgm_pkg::MAX_WIDTH];
  logic [sgm_pkg::LUMA_W-1:0] up_mem  [sgm_pkg::MAX_WIDTH];
  logic [sgm_pkg::LUMA_W-1:0] rd_mid_q, rd_up_q;

  logic [sgm_pkg::COL_W-1:0]  col_q, flush_q, c_q, f_q;
  logic [sgm_pkg::ROW_W-1:0]  row_q, r_q;
  logic [sgm_pkg::LUMA_W-1:0] lum_q;
  logic                       flast_q;
  logic [1:0]                 fi_q;
  sgm_pkg::win_t              win_q;

  logic [sgm_pkg::COL_W-1:0]  w_m1, f_cur, fcol, rd_addr;
  logic [sgm_pkg::COL_W:0]    fsum, fdec;
  logic [sgm_pkg::ROW_W-1:0]  h_eff;
  logic [sgm_pkg::LUMA_W-1:0] lum, pm, pt, ftop;
  logic                       flush_mode, in_fire, row_end, rd_en, mid_we, up_we;

  // effective frame size
  always_comb begin
    priority if (cfg_i.frame_width == '0) begin
      w_m1 = '0;
    end else if (32'(cfg_i.frame_width) > sgm_pkg::MAX_WIDTH) begin
      w_m1 = sgm_pkg::COL_W'(sgm_pkg::MAX_WIDTH - 1);
    end else begin
      w_m1 = sgm_pkg::COL_W'(cfg_i.frame_width - 1'b1);
    end
    priority if (cfg_i.frame_height == '0) begin
      h_eff = sgm_pkg::ROW_W'(1);
    end else if (32'(cfg_i.frame_height) > sgm_pkg::MAX_HEIGHT) begin
      h_eff = sgm_pkg::ROW_W'(sgm_pkg::MAX_HEIGHT);
    end else begin
      h_eff = sgm_pkg::ROW_W'(cfg_i.frame_height);
    end
  end

  // luma, flush column and window taps
  always_comb begin
    if (cfg_i.single_channel) begin
      lum = {red_i, 8'h00};
    end else begin
      lum = sgm_pkg::LUMA_W'(32'(red_i) * sgm_pkg::W_RED + 32'(green_i) * sgm_pkg::W_GREEN
                           + 32'(blue_i) * sgm_pkg::W_BLUE);
    end
    flush_mode = (row_q >= h_eff);
    f_cur      = (flush_q > w_m1) ? w_m1 : flush_q;
    row_end    = (c_q >= w_m1);
    fsum       = {1'b0, f_q} + (sgm_pkg::COL_W + 1)'(fi_q);
    fdec       = (fsum == '0) ? '0 : fsum - 1'b1;
    fcol       = (fdec > {1'b0, w_m1}) ? w_m1 : fdec[sgm_pkg::COL_W-1:0];
    pm         = (r_q == '0) ? lum_q : rd_mid_q;
    pt         = (r_q == '0) ? lum_q
               : ((r_q == sgm_pkg::ROW_W'(1)) ? rd_mid_q : rd_up_q);
    ftop       = (row_q <= sgm_pkg::ROW_W'(1)) ? rd_mid_q : rd_up_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sgm_pkg::FS_IDLE: begin
        if (in_valid_i) begin
          if (flush_mode) begin
            if (command_i == sgm_pkg::CMD_FLUSH) state_d = sgm_pkg::FS_FADDR;
          end else if (command_i == sgm_pkg::CMD_PIXEL) begin
            state_d = sgm_pkg::FS_PIX;
          end
        end
      end
      sgm_pkg::FS_PIX: begin
        if (r_q != '0 && c_q != '0) state_d = sgm_pkg::FS_EMIT1;
        else if (r_q != '0 && row_end) state_d = sgm_pkg::FS_EMIT2;
        else state_d = sgm_pkg::FS_IDLE;
      end
      sgm_pkg::FS_EMIT1: begin
        if (req_ready_i) state_d = row_end ? sgm_pkg::FS_EMIT2 : sgm_pkg::FS_IDLE;
      end
      sgm_pkg::FS_EMIT2: if (req_ready_i) state_d = sgm_pkg::FS_IDLE;
      sgm_pkg::FS_FADDR: state_d = sgm_pkg::FS_FDATA;
      sgm_pkg::FS_FDATA: state_d = (fi_q == 2'd2) ? sgm_pkg::FS_FEMIT : sgm_pkg::FS_FADDR;
      sgm_pkg::FS_FEMIT: if (req_ready_i) state_d = sgm_pkg::FS_IDLE;
      default:           state_d = sgm_pkg::FS_IDLE;
    endcase
  end

  // control outputs and job payload
  always_comb begin
    in_ready_o  = (state_q == sgm_pkg::FS_IDLE);
    in_fire     = in_valid_i && in_ready_o;
    rd_en       = 1'b0;
    rd_addr     = col_q;
    mid_we      = 1'b0;
    up_we       = 1'b0;
    req_valid_o = 1'b0;
    job_o.win   = win_q;
    job_o.x     = sgm_pkg::PIX_W'(c_q);
    job_o.y     = sgm_pkg::PIX_W'(r_q - 1'b1);
    job_o.last  = 1'b0;
    unique case (state_q)
      sgm_pkg::FS_IDLE: rd_en = in_fire && !flush_mode;
      sgm_pkg::FS_PIX: begin
        mid_we = 1'b1;
        up_we  = (r_q != '0);
      end
      sgm_pkg::FS_EMIT1: begin
        req_valid_o = 1'b1;
        job_o.x     = sgm_pkg::PIX_W'(c_q - 1'b1);
      end
      sgm_pkg::FS_EMIT2: req_valid_o = 1'b1;
      sgm_pkg::FS_FADDR: begin
        rd_en   = 1'b1;
        rd_addr = fcol;
      end
      sgm_pkg::FS_FDATA: begin
      end
      sgm_pkg::FS_FEMIT: begin
        req_valid_o = 1'b1;
        job_o.x     = sgm_pkg::PIX_W'(f_q);
        job_o.y     = sgm_pkg::PIX_W'(row_q - 1'b1);
        job_o.last  = flast_q;
      end
      default: begin
      end
    endcase
  end

  // line stores
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_mid_q <= mid_mem[rd_addr];
      rd_up_q  <= up_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_we) mid_mem[c_q] <= lum_q;
    if (up_we)  up_mem[c_q]  <= rd_mid_q;
  end

  // state, counters and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgm_pkg::FS_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= '0;
      win_q   <= '0;
      fi_q    <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        sgm_pkg::FS_IDLE: fi_q <= '0;
        sgm_pkg::FS_PIX: begin
          if (c_q == '0) begin
            for (int i = 0; i < 3; i++) begin
              win_q[i][0] <= pt;
              win_q[i][1] <= pm;
              win_q[i][2] <= lum_q;
            end
          end else begin
            win_q[0]    <= win_q[1];
            win_q[1]    <= win_q[2];
            win_q[2][0] <= pt;
            win_q[2][1] <= pm;
            win_q[2][2] <= lum_q;
          end
          if (row_end) begin
            col_q <= '0;
            row_q <= r_q + 1'b1;
          end else begin
            col_q <= c_q + 1'b1;
          end
        end
        sgm_pkg::FS_EMIT1: begin
          // right edge: replicate the last column for the final result of the row
          if (req_ready_i && row_end) begin
            win_q[0] <= win_q[1];
            win_q[1] <= win_q[2];
          end
        end
        sgm_pkg::FS_EMIT2: begin
        end
        sgm_pkg::FS_FADDR: begin
        end
        sgm_pkg::FS_FDATA: begin
          win_q[fi_q][0] <= ftop;
          win_q[fi_q][1] <= rd_mid_q;
          win_q[fi_q][2] <= rd_mid_q;
          fi_q           <= fi_q + 1'b1;
        end
        sgm_pkg::FS_FEMIT: begin
          if (req_ready_i) begin
            if (flast_q) begin
              col_q   <= '0;
              row_q   <= '0;
              flush_q <= '0;
            end else begin
              flush_q <= f_q + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // per-item capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      lum_q   <= lum;
      c_q     <= col_q;
      r_q     <= row_q;
      f_q     <= f_cur;
      flast_q <= (f_cur >= w_m1);
    end
  end

  // pixel processing only follows an input transfer
  a_pix_after_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sgm_pkg::FS_PIX) |-> $past(in_valid_i && in_ready_o))
    else $error("pixel step without transfer");

  // a pixel row in progress lies inside the frame
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sgm_pkg::FS_PIX) |-> (r_q < h_eff))
    else $error("pixel row beyond frame height");

  // flush reads stay within the active row
  a_flush_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sgm_pkg::FS_FADDR) |-> (rd_addr <= w_m1))
    else $error("flush read beyond row width");

endmodule

`default_nettype wire

// ----- rtl/core/sobel_gradient_magnitude.sv -----
// Sobel 3x3 gradient magnitude over an RGB8 raster stream.
// Input channel (in_valid_i/in_ready_o): command_i 0 carries a pixel, 1 a flush.
// Pixels arrive in raster order; results trail by one row, and once the last
// row is in, each flush transfer releases one bottom-row result, the final one
// flagged with last_of_frame_o. Commands that do not fit the frame position
// are dropped without a result.
// Output channel (out_valid_o/out_ready_i): coordinates, scaled gradients and
// scaled floor square root of their squared sum, from a result register.
// Configuration (cfg_valid_i/cfg_ready_o): always ready, write while idle.
// Flow: a pixel passes the window stage through its pixel and emit states, a
// flush through three address and data reads and an emit; each result then
// passes the gradient unit, whose bit-serial square root gives one root bit
// per cycle. A pixel gives up to two results, and the gradient unit takes a
// new job only once its last result has moved to the result register.
// Reset clears counters, window and configuration registers to their defaults;
// the line stores are not cleared, the first row of a frame fills them.
// When the receiver stalls, one result waits in the output register, the next
// waits in the gradient unit, and then the input stops taking transfers.
`default_nettype none

module sobel_gradient_magnitude (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           command_i,
  input  wire logic [sgm_pkg::CH_W-1:0]       red_i,
  input  wire logic [sgm_pkg::CH_W-1:0]       green_i,
  input  wire logic [sgm_pkg::CH_W-1:0]       blue_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [sgm_pkg::PIX_W-1:0]           pixel_x_o,
  output logic [sgm_pkg::PIX_W-1:0]           pixel_y_o,
  output logic signed [sgm_pkg::OUT_W-1:0]    grad_x_o,
  output logic signed [sgm_pkg::OUT_W-1:0]    grad_y_o,
  output logic [sgm_pkg::OUT_W-1:0]           magnitude_o,
  output logic                                last_of_frame_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [1:0]                     cfg_index_i,
  input  wire logic [sgm_pkg::CFG_W-1:0]      cfg_data_i
);

  sgm_pkg::cfg_t cfg_q;
  sgm_pkg::job_t job;
  logic          req_valid, req_ready;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= sgm_pkg::CFG_W'(sgm_pkg::WIDTH_RST);
      cfg_q.frame_height   <= sgm_pkg::CFG_W'(sgm_pkg::HEIGHT_RST);
      cfg_q.gain           <= sgm_pkg::CFG_W'(sgm_pkg::GAIN_RST);
      cfg_q.single_channel <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sgm_pkg::cfg_reg_e'(cfg_index_i))
        sgm_pkg::REG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data_i;
        sgm_pkg::REG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data_i;
        sgm_pkg::REG_GAIN:           cfg_q.gain           <= cfg_data_i;
        sgm_pkg::REG_SINGLE_CHANNEL: cfg_q.single_channel <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  sgm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .job_o       (job)
  );

  sgm_grad u_grad (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .gain_i          (cfg_q.gain),
    .req_valid_i     (req_valid),
    .req_ready_o     (req_ready),
    .job_i           (job),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .grad_x_o        (grad_x_o),
    .grad_y_o        (grad_y_o),
    .magnitude_o     (magnitude_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

`default_nettype wire

// ----- tb/sobel_gradient_magnitude_checker.sv -----
`default_nettype none

module sobel_gradient_magnitude_checker
  import sgm_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_ready_i,
  input  wire logic                     command_i,
  input  wire logic [CH_W-1:0]          red_i,
  input  wire logic [CH_W-1:0]          green_i,
  input  wire logic [CH_W-1:0]          blue_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     out_ready_i,
  input  wire logic [PIX_W-1:0]         pixel_x_i,
  input  wire logic [PIX_W-1:0]         pixel_y_i,
  input  wire logic signed [OUT_W-1:0]  grad_x_i,
  input  wire logic signed [OUT_W-1:0]  grad_y_i,
  input  wire logic [OUT_W-1:0]         magnitude_i,
  input  wire logic                     last_of_frame_i,
  input  wire logic                     cfg_valid_i,
  input  wire logic                     cfg_ready_i,
  input  wire logic [1:0]               cfg_index_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);

  typedef struct packed {
    logic [PIX_W-1:0]        x;
    logic [PIX_W-1:0]        y;
    logic signed [OUT_W-1:0] gx;
    logic signed [OUT_W-1:0] gy;
    logic [OUT_W-1:0]        mag;
    logic                    last;
  } grad_result_t;

  // gradients still owed by the block, oldest first
  grad_result_t due_gradients[$];

  // mirrored registers
  int   width_reg;
  int   height_reg;
  int   gain_reg;
  logic mono_reg;

  // luma line stores, 3x3 window [column][row] and raster position
  logic [LUMA_W-1:0] upper_mem  [MAX_WIDTH];
  logic [LUMA_W-1:0] middle_mem [MAX_WIDTH];
  logic [LUMA_W-1:0] win [3][3];
  int   col_cnt;
  int   row_cnt;
  int   flush_cnt;

  int   fails;
  int   checked;

  function automatic int clamp_dim(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // floor square root, one result bit per step from the top
  function automatic longint root_floor(longint v);
    longint r;
    longint trial;
    r = 0;
    for (int k = 20; k >= 0; k--) begin
      trial = r | (longint'(1) << k);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // sobel over the current window, scaled by the gain
  task automatic queue_gradient(int x, int y, logic last);
    longint       dx;
    longint       dy;
    longint       g;
    longint       root;
    grad_result_t res;
    dx = (longint'(win[2][0]) + 2 * longint'(win[2][1]) + longint'(win[2][2]))
       - (longint'(win[0][0]) + 2 * longint'(win[0][1]) + longint'(win[0][2]));
    dy = (longint'(win[0][2]) + 2 * longint'(win[1][2]) + longint'(win[2][2]))
       - (longint'(win[0][0]) + 2 * longint'(win[1][0]) + longint'(win[2][0]));
    g = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;
    root = root_floor(dx * dx + dy * dy);
    res.x    = PIX_W'(x);
    res.y    = PIX_W'(y);
    res.gx   = OUT_W'((dx * g) >>> FRAC_W);
    res.gy   = OUT_W'((dy * g) >>> FRAC_W);
    res.mag  = OUT_W'((root * g) >> FRAC_W);
    res.last = last;
    due_gradients.push_back(res);
  endtask

  task automatic slide_window(logic [LUMA_W-1:0] t, logic [LUMA_W-1:0] m,
                              logic [LUMA_W-1:0] b);
    for (int row = 0; row < 3; row++) begin
      win[0][row] = win[1][row];
      win[1][row] = win[2][row];
    end
    win[2][0] = t;
    win[2][1] = m;
    win[2][2] = b;
  endtask

  // one input transfer: advance the raster and owe its results
  task automatic advance_raster(logic cmd, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                logic [CH_W-1:0] b);
    int                w;
    int                h;
    int                c;
    int                f;
    int                col;
    logic [LUMA_W-1:0] lum;
    logic [LUMA_W-1:0] t;
    logic [LUMA_W-1:0] m;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);

    // bottom row, one result per flush
    if (row_cnt >= h) begin
      if (cmd != CMD_FLUSH) return;
      f = (flush_cnt > w - 1) ? w - 1 : flush_cnt;
      for (int i = 0; i < 3; i++) begin
        col = f + i;
        col = (col == 0) ? 0 : col - 1;
        if (col > w - 1) col = w - 1;
        m = middle_mem[col];
        win[i][0] = (row_cnt <= 1) ? m : upper_mem[col];
        win[i][1] = m;
        win[i][2] = m;
      end
      queue_gradient(f, row_cnt - 1, f >= w - 1);
      if (f >= w - 1) begin
        col_cnt   = 0;
        row_cnt   = 0;
        flush_cnt = 0;
      end else begin
        flush_cnt = f + 1;
      end
      return;
    end
    if (cmd != CMD_PIXEL) return;

    if (mono_reg) lum = {r, 8'h00};
    else          lum = LUMA_W'(W_RED * r + W_GREEN * g + W_BLUE * b);

    // line stores roll down one row at this column
    c = (col_cnt > MAX_WIDTH - 1) ? MAX_WIDTH - 1 : col_cnt;
    if (row_cnt == 0) begin
      middle_mem[c] = lum;
      t = lum;
      m = lum;
    end else begin
      m = middle_mem[c];
      t = (row_cnt == 1) ? m : upper_mem[c];
      upper_mem[c]  = m;
      middle_mem[c] = lum;
    end

    // left edge fills the window, otherwise the previous column is done
    if (c == 0) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] = t;
        win[i][1] = m;
        win[i][2] = lum;
      end
    end else begin
      slide_window(t, m, lum);
      if (row_cnt >= 1) queue_gradient(c - 1, row_cnt - 1, 1'b0);
    end

    // right edge repeats the last column
    if (c >= w - 1) begin
      if (row_cnt >= 1) begin
        slide_window(win[2][0], win[2][1], win[2][2]);
        queue_gradient(c, row_cnt - 1, 1'b0);
      end
      col_cnt = 0;
      row_cnt = row_cnt + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic compare_gradient();
    grad_result_t got;
    grad_result_t want;
    got = '{x: pixel_x_i, y: pixel_y_i, gx: grad_x_i, gy: grad_y_i,
            mag: magnitude_i, last: last_of_frame_i};
    if (due_gradients.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("unexpected result at (%0d,%0d) gx %0d gy %0d mag %0d last %0d",
                 got.x, got.y, got.gx, got.gy, got.mag, got.last);
      return;
    end
    want = due_gradients.pop_front();
    checked++;
    if (got.x !== want.x || got.y !== want.y || got.gx !== want.gx ||
        got.gy !== want.gy || got.mag !== want.mag || got.last !== want.last) begin
      fails++;
      if (fails <= 10)
        $display({"mismatch exp/act: x %0d/%0d y %0d/%0d gx %0d/%0d gy %0d/%0d",
                  " mag %0d/%0d last %0d/%0d"},
                 want.x, got.x, want.y, got.y, want.gx, got.gx, want.gy, got.gy,
                 want.mag, got.mag, want.last, got.last);
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_gradients.delete();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      gain_reg   = GAIN_RST;
      mono_reg   = 1'b0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_mem[i]  = '0;
        middle_mem[i] = '0;
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      end
      col_cnt   = 0;
      row_cnt   = 0;
      flush_cnt = 0;
      fails     = 0;
      checked   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH:    width_reg  = cfg_data_i;
          REG_FRAME_HEIGHT:   height_reg = cfg_data_i;
          REG_GAIN:           gain_reg   = cfg_data_i;
          REG_SINGLE_CHANNEL: mono_reg   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) advance_raster(command_i, red_i, green_i, blue_i);
      if (out_valid_i && out_ready_i) compare_gradient();
    end
    fail_count_o <= fails;
    pending_o    <= due_gradients.size();
    checked_o    <= checked;
  end

endmodule

`default_nettype wire

// ----- tb/sobel_gradient_magnitude_tb.sv -----
`default_nettype none

module sobel_gradient_magnitude_tb;
  import sgm_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 60;
  localparam int ITEM_TARGET  = 650;
  localparam int IDLE_PCT     = 37;
  localparam int NOISE_PCT    = 6;
  localparam int RUN_LIMIT    = 6_000_000;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic                    command_i   = 1'b0;
  logic [CH_W-1:0]         red_i       = '0;
  logic [CH_W-1:0]         green_i     = '0;
  logic [CH_W-1:0]         blue_i      = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [PIX_W-1:0]        pixel_x_o;
  logic [PIX_W-1:0]        pixel_y_o;
  logic signed [OUT_W-1:0] grad_x_o;
  logic signed [OUT_W-1:0] grad_y_o;
  logic [OUT_W-1:0]        magnitude_o;
  logic                    last_of_frame_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [1:0]              cfg_index_i = '0;
  logic [CFG_W-1:0]        cfg_data_i  = '0;

  int fail_count;
  int pending;
  int checked;

  int idle_pct  = IDLE_PCT;
  int stall_pct = IDLE_PCT;

  // raster position as the block should see it, for choosing commands
  int eff_w     = WIDTH_RST;
  int eff_h     = HEIGHT_RST;
  int col_pos   = 0;
  int row_pos   = 0;
  int flush_pos = 0;
  bit frame_done;

  int items_sent;
  int noise_sent;
  int frames;
  int reg_writes;

  sobel_gradient_magnitude u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .grad_x_o        (grad_x_o),
    .grad_y_o        (grad_y_o),
    .magnitude_o     (magnitude_o),
    .last_of_frame_o (last_of_frame_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  sobel_gradient_magnitude_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .command_i       (command_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_x_i       (pixel_x_o),
    .pixel_y_i       (pixel_y_o),
    .grad_x_i        (grad_x_o),
    .grad_y_i        (grad_y_o),
    .magnitude_i     (magnitude_o),
    .last_of_frame_i (last_of_frame_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  function automatic int eff_dim(int v);
    if (v == 0) return 1;
    return (v > MAX_WIDTH) ? MAX_WIDTH : v;
  endfunction

  // returns 1 when the command fits the position and is not dropped
  function automatic bit advance_position(cmd_e cmd);
    int c;
    int f;
    if (row_pos >= eff_h) begin
      if (cmd != CMD_FLUSH) return 1'b0;
      f = (flush_pos > eff_w - 1) ? eff_w - 1 : flush_pos;
      if (f >= eff_w - 1) begin
        col_pos    = 0;
        row_pos    = 0;
        flush_pos  = 0;
        frame_done = 1'b1;
      end else begin
        flush_pos = f + 1;
      end
      return 1'b1;
    end
    if (cmd != CMD_PIXEL) return 1'b0;
    c = (col_pos > MAX_WIDTH - 1) ? MAX_WIDTH - 1 : col_pos;
    if (c >= eff_w - 1) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
    return 1'b1;
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(cmd_e cmd, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                           logic [CH_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (advance_position(cmd)) items_sent++;
    else                       noise_sent++;
  endtask

  // stop input, wait for every owed result, then let the window stage go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reg_writes++;
    case (idx)
      REG_FRAME_WIDTH:  eff_w = eff_dim(val & 12'hFFF);
      REG_FRAME_HEIGHT: eff_h = eff_dim(val & 12'hFFF);
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CH_W-1:0] shade(int mode, int col, int row, int ch);
    case (mode)
      0:       return CH_W'($urandom_range(255));
      1:       return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return CH_W'(col * 61 + row * 97 + ch * 29 + $urandom_range(7));
    endcase
  endfunction

  task automatic pick_frame_setup();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5)       write_reg(REG_FRAME_WIDTH, 0);
    else if (roll < 75) write_reg(REG_FRAME_WIDTH, $urandom_range(1, 12));
    else                write_reg(REG_FRAME_WIDTH, $urandom_range(13, 40));
    roll = $urandom_range(99);
    if (roll < 5) write_reg(REG_FRAME_HEIGHT, 0);
    else          write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 6));
    roll = $urandom_range(99);
    if (roll < 50)      write_reg(REG_GAIN, $urandom_range(0, GAIN_MAX));
    else if (roll < 70) write_reg(REG_GAIN, GAIN_RST);
    else if (roll < 80) write_reg(REG_GAIN, GAIN_MAX);
    else if (roll < 90) write_reg(REG_GAIN, 0);
    else                write_reg(REG_GAIN, $urandom_range(GAIN_MAX + 1, 4095));
    write_reg(REG_SINGLE_CHANNEL, $urandom_range(1));
    end_writes();
  endtask

  // register change in the middle of a frame; width never grows
  task automatic nudge_setup();
    settle();
    case ($urandom_range(3))
      0:       write_reg(REG_GAIN, $urandom_range(0, 4095));
      1:       write_reg(REG_SINGLE_CHANNEL, $urandom_range(1));
      2:       write_reg(REG_FRAME_WIDTH, $urandom_range(1, eff_w));
      default: write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 8));
    endcase
    end_writes();
  endtask

  initial begin
    int   mode;
    cmd_e want;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 3x2 frame of channel extremes, a stray command in each phase
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 2);
    write_reg(REG_GAIN, GAIN_RST);
    write_reg(REG_SINGLE_CHANNEL, 0);
    end_writes();
    send_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    send_item(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_PIXEL, 8'hFF, 8'h00, 8'h00);
    send_item(CMD_PIXEL, 8'h00, 8'hFF, 8'h00);
    send_item(CMD_PIXEL, 8'h00, 8'h00, 8'hFF);
    send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_PIXEL, 8'hAA, 8'h55, 8'hAA);
    repeat (3) send_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);

    // zero sizes act as one, gain above the top clamps, single channel
    settle();
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    write_reg(REG_GAIN, 4095);
    write_reg(REG_SINGLE_CHANNEL, 1);
    end_writes();
    send_item(CMD_PIXEL, 8'hFF, 8'h00, 8'h00);
    send_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);

    // oversized frame, then width and height cut below the position reached
    settle();
    write_reg(REG_FRAME_WIDTH, 4095);
    write_reg(REG_FRAME_HEIGHT, 4095);
    write_reg(REG_GAIN, 0);
    write_reg(REG_SINGLE_CHANNEL, 0);
    end_writes();
    for (int i = 0; i < 4; i++) send_item(CMD_PIXEL, shade(0, i, 0, 0),
                                          shade(0, i, 0, 1), shade(0, i, 0, 2));
    settle();
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_GAIN, GAIN_MAX);
    end_writes();
    send_item(CMD_PIXEL, 8'h12, 8'h34, 8'h56);
    send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    settle();
    write_reg(REG_FRAME_HEIGHT, 1);
    end_writes();
    repeat (2) send_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    frames = 3;

    // random frames, mostly well formed with some stray commands
    while (items_sent < ITEM_TARGET) begin
      settle();
      pick_frame_setup();
      mode = $urandom_range(2);
      frame_done = 1'b0;
      while (!frame_done) begin
        if (items_sent >= 250 && items_sent < 400) begin
          idle_pct  = 0;
          stall_pct = 0;
        end else begin
          idle_pct  = IDLE_PCT;
          stall_pct = IDLE_PCT;
        end
        if ($urandom_range(99) == 0) nudge_setup();
        want = (row_pos >= eff_h) ? CMD_FLUSH : CMD_PIXEL;
        if ($urandom_range(99) < NOISE_PCT)
          want = (want == CMD_PIXEL) ? CMD_FLUSH : CMD_PIXEL;
        send_item(want, shade(mode, col_pos, row_pos, 0), shade(mode, col_pos, row_pos, 1),
                  shade(mode, col_pos, row_pos, 2));
      end
      frames++;
    end

    settle();
    $display("summary: %0d items in %0d frames, %0d dropped commands, %0d register writes",
             items_sent, frames, noise_sent, reg_writes);
    $display("summary: %0d results checked, %0d failures", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
